### src/scg_pkg.sv
// ----------------------------------------------------------------------------
// scg_pkg
// Shared types, codes and helpers of the scan column gap filler.
// ----------------------------------------------------------------------------
package scg_pkg;

	// fixed field widths
	localparam int unsigned ZinW = 18;
	localparam int unsigned AinW = 19;
	localparam int unsigned RngW = 24;
	localparam int unsigned AngW = 20;
	localparam int unsigned GapW = 6;
	localparam int unsigned SpcW = 17;
	localparam int unsigned EbW  = 8;
	localparam int unsigned AccW = 25;

	localparam int unsigned MaxGapDefault = 63;

	localparam logic signed [SpcW-1:0] SpacingReset = -17'sd41;
	localparam logic [EbW-1:0]         EmptyReset   = 8'd1;

	// register indexes
	localparam logic RegSpacing = 1'b0;
	localparam logic RegEmpty   = 1'b1;

	// fill status codes
	localparam logic [2:0] StMeas    = 3'd0;
	localparam logic [2:0] StInterp  = 3'd1;
	localparam logic [2:0] StLead    = 3'd2;
	localparam logic [2:0] StTrail   = 3'd3;
	localparam logic [2:0] StRising  = 3'd4;
	localparam logic [2:0] StEmpty   = 3'd5;
	localparam logic [2:0] StTooLong = 3'd6;

	typedef struct packed {
		logic load;
		logic emit_run;
		logic emit_meas;
		logic div_load;
		logic last;
	} scg_cmd_t;

	typedef struct packed {
		logic [GapW-1:0] cnt;
		logic            need_div;
		logic            meas;
		logic            div_busy;
	} scg_sts_t;

	function automatic logic signed [AngW-1:0] sat20(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] hi;
		logic signed [AccW-1:0] lo;
		hi = 25'sd524287;
		lo = -25'sd524288;
		if (v > hi) begin
			return 20'sd524287;
		end else if (v < lo) begin
			return -20'sd524288;
		end else begin
			return v[AngW-1:0];
		end
	endfunction

endpackage

### src/scan_column_gap_fill.sv
// ----------------------------------------------------------------------------
// scan_column_gap_fill
// Fills runs of empty scan points in a column by interpolation/extrapolation.
//
//  channel | dir | handshake        | contents
//  s_*     | in  | tvalid/tready    | scan point, tlast = column end
//  m_*     | out | tvalid/tready    | filled point, tlast = column last
//  apb     | in  | psel/penable     | row_spacing @0x0, empty_below @0x4
//
// An input point is taken only while the sequencer is idle; then each result it
// releases passes through the output register. An interpolated run is first
// divided in the bit-serial divider. No clearing pass after reset. A stalled
// output holds the sequencer; the input waits only while a point is being
// worked on.
// ----------------------------------------------------------------------------
module scan_column_gap_fill #(
	parameter int unsigned MAX_GAP = scg_pkg::MaxGapDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // zenith_in[17:0], azimuth_in[36:18], range_value[60:37]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // zenith_out[19:0], azimuth_out[39:20]
	output logic [3:0]  m_tuser,   // fill_status[2:0], run_last[3]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import scg_pkg::*;

	logic signed [SpcW-1:0] spacing_q;
	logic [EbW-1:0]         eb_q;
	scg_cmd_t               cmd;
	scg_sts_t               sts;
	logic signed [AngW-1:0] zo, ao;
	logic [2:0]             fst;
	logic                   rlast;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SpacingReset;
			eb_q      <= EmptyReset;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				RegSpacing: spacing_q <= pwdata[SpcW-1:0];
				RegEmpty:   eb_q      <= pwdata[EbW-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			RegSpacing: prdata = {{(32-SpcW){1'b0}}, spacing_q};
			RegEmpty:   prdata = {{(32-EbW){1'b0}}, eb_q};
			default:    prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	scg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scg_datapath #(
		.MAX_GAP (MAX_GAP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.spacing     (spacing_q),
		.empty_below (eb_q),
		.zenith_in   (s_tdata[17:0]),
		.azimuth_in  (s_tdata[36:18]),
		.range_value (s_tdata[60:37]),
		.column_end  (s_tlast),
		.zenith_out  (zo),
		.azimuth_out (ao),
		.fill_status (fst),
		.column_last (m_tlast),
		.run_last    (rlast)
	);

	assign m_tdata = {ao, zo};
	assign m_tuser = {rlast, fst};

	// unfilled results carry zero angles
	a_unfilled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == StRising || m_tuser[2:0] == StEmpty ||
		m_tuser[2:0] == StTooLong) |-> m_tdata == '0)
		else $error("unfilled result with nonzero angles");

	// a measured point always closes its request's results
	a_meas_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == StMeas |-> m_tuser[3])
		else $error("measured result not marked last");

	// column end only on the final result of a request
	a_col_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[3])
		else $error("column last without run last");

endmodule

### src/scg_div.sv
// ----------------------------------------------------------------------------
// scg_div
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// ----------------------------------------------------------------------------
module scg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [scg_pkg::ZinW-1:0]     dividend,
	input  logic [scg_pkg::GapW-1:0]     divisor,
	output logic                         busy,
	output logic [scg_pkg::ZinW-1:0]     quotient,
	output logic [scg_pkg::GapW-1:0]     remainder
);
	import scg_pkg::*;

	localparam int unsigned CntW = $clog2(ZinW);

	logic [GapW-1:0] rem_q;
	logic [ZinW-1:0] quo_q;
	logic [GapW-1:0] div_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [GapW:0]   trial;
	logic [GapW:0]   diff;
	logic            ge;

	// trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[ZinW-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	// advance one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(ZinW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[GapW-1:0] : trial[GapW-1:0];
			quo_q <= {quo_q[ZinW-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### src/scg_datapath.sv
// ----------------------------------------------------------------------------
// scg_datapath
// Column state, point classification, fill generators and output register.
// ----------------------------------------------------------------------------
module scg_datapath #(
	parameter int unsigned MAX_GAP = scg_pkg::MaxGapDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  scg_pkg::scg_cmd_t                 cmd,
	output scg_pkg::scg_sts_t                 sts,
	input  logic signed [scg_pkg::SpcW-1:0]   spacing,
	input  logic [scg_pkg::EbW-1:0]           empty_below,
	input  logic [scg_pkg::ZinW-1:0]          zenith_in,
	input  logic [scg_pkg::AinW-1:0]          azimuth_in,
	input  logic [scg_pkg::RngW-1:0]          range_value,
	input  logic                              column_end,
	output logic signed [scg_pkg::AngW-1:0]   zenith_out,
	output logic signed [scg_pkg::AngW-1:0]   azimuth_out,
	output logic [2:0]                        fill_status,
	output logic                              column_last,
	output logic                              run_last
);
	import scg_pkg::*;

	// column state
	logic [GapW-1:0] gl_q;
	logic            gas_q;
	logic            hv_q;
	logic [ZinW-1:0] lvz_q;
	logic [AinW-1:0] lva_q;

	// run context
	logic [2:0]             mode_q;
	logic [ZinW-1:0]        zin_q;
	logic [AinW-1:0]        ain_q;
	logic                   ce_q;
	logic [ZinW-1:0]        bz_q;
	logic [AinW-1:0]        ba_q;
	logic signed [AccW-1:0] acc_q;
	logic [GapW-1:0]        m_q;
	logic [ZinW-1:0]        q0_q, q_q;
	logic [GapW-1:0]        r0_q, r_q;

	// output register
	logic signed [AngW-1:0] oz_q, oa_q;
	logic [2:0]             ost_q;
	logic                   olast_q, ocol_q;

	logic            empty, rising, too_long;
	logic [GapW:0]   n_e;
	logic [2:0]      code;
	logic [GapW-1:0] cnt;
	logic            need_div, meas;
	logic signed [AccW-2:0] prod;
	logic signed [AccW-1:0] acc_init;
	logic [GapW-1:0] div_m;
	logic [ZinW-1:0] quo;
	logic [GapW-1:0] rem;
	logic            busy;
	logic [GapW:0]   rsum;
	logic            rwrap;

	// classify the offered point against the column state
	always_comb begin
		empty    = range_value < {{(RngW-EbW){1'b0}}, empty_below};
		n_e      = {1'b0, gl_q} + 1'b1;
		too_long = n_e >= (GapW+1)'(MAX_GAP);
		rising   = zenith_in > lvz_q;
		code     = StMeas;
		cnt      = '0;
		need_div = 1'b0;
		meas     = 1'b0;
		if (empty) begin
			if (too_long || column_end) begin
				cnt = n_e[GapW-1:0];
			end
			if (too_long) begin
				code = StTooLong;
			end else if (gas_q) begin
				code = StEmpty;
			end else if (hv_q) begin
				code = StTrail;
			end else begin
				code = StTooLong;
			end
		end else begin
			meas = 1'b1;
			cnt  = gl_q;
			if (gas_q) begin
				code = StLead;
			end else if (hv_q) begin
				code     = rising ? StRising : StInterp;
				need_div = !rising && (gl_q != '0);
			end else begin
				code = StTooLong;
			end
		end
	end

	// first zenith of an extrapolated run
	always_comb begin
		prod  = spacing * $signed({1'b0, gl_q});
		div_m = gl_q + 1'b1;
		if (code == StLead) begin
			acc_init = $signed({{(AccW-ZinW){1'b0}}, zenith_in}) - AccW'(prod);
		end else begin
			acc_init = $signed({{(AccW-ZinW){1'b0}}, lvz_q}) + AccW'(spacing);
		end
	end

	scg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.load && need_div),
		.dividend  (lvz_q - zenith_in),
		.divisor   (div_m),
		.busy      (busy),
		.quotient  (quo),
		.remainder (rem)
	);

	always_comb begin
		sts.cnt      = cnt;
		sts.need_div = need_div;
		sts.meas     = meas;
		sts.div_busy = busy;
	end

	// update column state on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q  <= '0;
			gas_q <= 1'b1;
			hv_q  <= 1'b0;
			lvz_q <= '0;
			lva_q <= '0;
		end else if (cmd.load) begin
			if (empty) begin
				if (too_long) begin
					gl_q  <= '0;
					gas_q <= column_end;
					hv_q  <= 1'b0;
				end else if (column_end) begin
					gl_q  <= '0;
					gas_q <= 1'b1;
					hv_q  <= 1'b0;
				end else begin
					gl_q <= n_e[GapW-1:0];
				end
			end else begin
				lvz_q <= zenith_in;
				lva_q <= azimuth_in;
				gl_q  <= '0;
				gas_q <= column_end;
				hv_q  <= !column_end;
			end
		end
	end

	// interpolation remainder step
	always_comb begin
		rsum  = {1'b0, r_q} + {1'b0, r0_q};
		rwrap = rsum >= {1'b0, m_q};
	end

	// hold run context, advance generators
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= code;
			zin_q  <= zenith_in;
			ain_q  <= azimuth_in;
			ce_q   <= column_end;
			bz_q   <= lvz_q;
			ba_q   <= (code == StLead) ? azimuth_in : lva_q;
			acc_q  <= acc_init;
			m_q    <= div_m;
		end else if (cmd.emit_run) begin
			acc_q <= acc_q + AccW'(spacing);
			q_q   <= q_q + q0_q + ZinW'(rwrap);
			r_q   <= rwrap ? GapW'(rsum - {1'b0, m_q}) : rsum[GapW-1:0];
		end
		if (cmd.div_load) begin
			q0_q <= quo;
			q_q  <= quo;
			r0_q <= rem;
			r_q  <= rem;
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (cmd.emit_meas) begin
			oz_q    <= $signed({{(AngW-ZinW){1'b0}}, zin_q});
			oa_q    <= $signed({{(AngW-AinW){1'b0}}, ain_q});
			ost_q   <= StMeas;
			olast_q <= 1'b1;
			ocol_q  <= ce_q;
		end else if (cmd.emit_run) begin
			ost_q   <= mode_q;
			olast_q <= cmd.last;
			ocol_q  <= cmd.last && ce_q;
			case (mode_q)
				StLead, StTrail: begin
					oz_q <= sat20(acc_q);
					oa_q <= $signed({{(AngW-AinW){1'b0}}, ba_q});
				end
				StInterp: begin
					oz_q <= $signed({{(AngW-ZinW){1'b0}}, bz_q - q_q});
					oa_q <= $signed({{(AngW-AinW){1'b0}}, ba_q});
				end
				default: begin
					oz_q <= '0;
					oa_q <= '0;
				end
			endcase
		end
	end

	assign zenith_out  = oz_q;
	assign azimuth_out = oa_q;
	assign fill_status = ost_q;
	assign column_last = ocol_q;
	assign run_last    = olast_q;

endmodule

### src/scg_ctrl.sv
// ----------------------------------------------------------------------------
// scg_ctrl
// Sequencer: accepts a point, waits on the divider, emits the run and point.
// ----------------------------------------------------------------------------
module scg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  scg_pkg::scg_sts_t  sts,
	output scg_pkg::scg_cmd_t  cmd
);
	import scg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_RUN,
		S_MEAS
	} state_t;

	state_t          state_q;
	logic [GapW-1:0] left_q;
	logic            meas_q;
	logic            ovalid_q;
	logic            slot;

	assign slot = !ovalid_q || out_ready;

	// commands
	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.div_load  = (state_q == S_DIV) && !sts.div_busy;
		cmd.emit_run  = (state_q == S_RUN) && slot;
		cmd.emit_meas = (state_q == S_MEAS) && slot;
		cmd.last      = (state_q == S_MEAS) || ((left_q == GapW'(1)) && !meas_q);
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			left_q   <= '0;
			meas_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.emit_run || cmd.emit_meas) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						left_q <= sts.cnt;
						meas_q <= sts.meas;
						if (sts.need_div) begin
							state_q <= S_DIV;
						end else if (sts.cnt != '0) begin
							state_q <= S_RUN;
						end else if (sts.meas) begin
							state_q <= S_MEAS;
						end
					end
				end
				S_DIV: begin
					if (!sts.div_busy) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (slot) begin
						left_q <= left_q - 1'b1;
						if (left_q == GapW'(1)) begin
							state_q <= meas_q ? S_MEAS : S_IDLE;
						end
					end
				end
				S_MEAS: begin
					if (slot) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;

endmodule
